FILE: sv/ol_pkg.sv
`timescale 1ns / 1ps

package ol_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VAL_W     = 32;
    localparam int ACT_W     = 3;
    localparam int POS_W     = 5;
    localparam int STAT_W    = 2;
    localparam int CNT_W     = 5;
    localparam int IN_W      = 40;
    localparam int OUT_W     = 40;

    typedef enum logic [ACT_W-1:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_BACK  = 3'd1,
        ACT_INS_POS   = 3'd2,
        ACT_DEL_FRONT = 3'd3,
        ACT_DEL_BACK  = 3'd4,
        ACT_LIST      = 3'd5
    } act_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_BADPOS = 2'd2,
        STAT_FULL   = 2'd3
    } stat_t;

    typedef enum logic [2:0] {
        SEL_HOLD,
        SEL_NEW,
        SEL_LEFT,
        SEL_RIGHT,
        SEL_HEAD
    } sel_t;

endpackage

FILE: sv/ordered_list_with_positional_insert_core.sv
`timescale 1ns / 1ps

// Bounded ordered list of signed 32-bit values held in a row of shifting cells.
// Input stream s_*: one transaction per action (insert front/back/at position,
// delete front/back, list). Output stream m_*: one transaction per result,
// carrying status, element, and count; tlast marks the final result.
// On an insert or delete, each cell loads, holds, or takes a neighbor's value
// as the transaction is accepted; the result sits in the output register on
// the next cycle, and a new transaction can be taken in that same cycle if the
// receiver takes the result. A listing rotates the occupied cells one step
// per cycle while the output register is free, emits the front cell with each
// step (one result per element), and returns the row to its original order;
// input is held off while it runs.
// When the receiver stalls, the output register holds and the input is held
// off until the pending result is taken.
// Reset empties the list and the output register; cell contents are
// undefined until written.
module ordered_list_with_positional_insert_core
    import ol_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // action[2:0], value[34:3], position[39:35]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // status[1:0], element[33:2], count[38:34], zero[39]
    output logic             m_tlast
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LIST = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     occ_reg, occ_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic              mval_reg, mval_next;
    logic [STAT_W-1:0] mstat_reg, mstat_next;
    logic [VAL_W-1:0]  melem_reg, melem_next;
    logic [CNT_W-1:0]  mcnt_reg, mcnt_next;
    logic              mlast_reg, mlast_next;

    logic              out_free;
    logic              in_acc;
    logic [ACT_W-1:0]  act;
    logic [VAL_W-1:0]  in_val;
    logic [POS_W-1:0]  in_pos;
    logic              full;
    logic              do_ins, do_delf, do_rot;
    logic [CW-1:0]     slot;
    logic [CW-1:0]     last_idx;
    logic [PW-1:0]     pos_ext, lim_ext, occn_ext;

    logic [VAL_W-1:0]  q [DEPTH];
    sel_t              sel [DEPTH];

    assign out_free = !mval_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_acc   = s_tvalid && s_tready;
    assign act      = s_tdata[2:0];
    assign in_val   = s_tdata[34:3];
    assign in_pos   = s_tdata[39:35];
    assign full     = (occ_reg == CW'(DEPTH));
    assign last_idx = occ_reg - CW'(1);
    assign pos_ext  = PW'(in_pos);
    assign lim_ext  = PW'(occ_reg) + PW'(1);
    assign occn_ext = PW'(occ_next);

    always_comb
    begin
        state_next = state_reg;
        occ_next   = occ_reg;
        rem_next   = rem_reg;
        mval_next  = mval_reg && !m_tready;
        mstat_next = mstat_reg;
        melem_next = melem_reg;
        mlast_next = mlast_reg;
        do_ins     = 1'b0;
        do_delf    = 1'b0;
        do_rot     = 1'b0;
        slot       = '0;
        if (in_acc)
        begin
            mval_next  = 1'b1;
            mstat_next = STAT_OK;
            melem_next = '0;
            mlast_next = 1'b1;
            unique case (act)
                ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS:
                begin
                    if (act == ACT_INS_FRONT)
                        slot = '0;
                    else if (act == ACT_INS_BACK)
                        slot = occ_reg;
                    else
                        slot = CW'(pos_ext - PW'(1));
                    if (act == ACT_INS_POS && (in_pos == '0 || pos_ext > lim_ext))
                        mstat_next = STAT_BADPOS;
                    else if (full)
                        mstat_next = STAT_FULL;
                    else
                    begin
                        do_ins   = 1'b1;
                        occ_next = occ_reg + CW'(1);
                    end
                end
                ACT_DEL_FRONT, ACT_DEL_BACK:
                begin
                    if (occ_reg == '0)
                        mstat_next = STAT_EMPTY;
                    else
                    begin
                        do_delf  = (act == ACT_DEL_FRONT);
                        occ_next = occ_reg - CW'(1);
                    end
                end
                ACT_LIST:
                begin
                    if (occ_reg == '0)
                        mstat_next = STAT_EMPTY;
                    else
                    begin
                        mval_next  = 1'b0;
                        state_next = ST_LIST;
                        rem_next   = occ_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == ST_LIST && out_free)
        begin
            do_rot     = 1'b1;
            mval_next  = 1'b1;
            mstat_next = STAT_OK;
            melem_next = q[0];
            mlast_next = (rem_reg == CW'(1));
            rem_next   = rem_reg - CW'(1);
            if (rem_reg == CW'(1))
                state_next = ST_IDLE;
        end
    end

    assign mcnt_next = occn_ext[CNT_W-1:0];

    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            always_comb
            begin
                priority if (do_ins)
                begin
                    if (CW'(i) < slot)
                        sel[i] = SEL_HOLD;
                    else if (CW'(i) == slot)
                        sel[i] = SEL_NEW;
                    else
                        sel[i] = SEL_LEFT;
                end
                else if (do_delf)
                    sel[i] = SEL_RIGHT;
                else if (do_rot)
                    sel[i] = (CW'(i) == last_idx) ? SEL_HEAD : SEL_RIGHT;
                else
                    sel[i] = SEL_HOLD;
            end

            ol_cell u_cell (
                .clk       (clk),
                .sel       (sel[i]),
                .new_val   (in_val),
                .left_val  (q[(i == 0) ? 0 : i - 1]),
                .right_val (q[(i == DEPTH - 1) ? i : i + 1]),
                .head_val  (q[0]),
                .q         (q[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
            rem_reg   <= '0;
            mval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            rem_reg   <= rem_next;
            mval_reg  <= mval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mval_next && out_free)
        begin
            mstat_reg <= mstat_next;
            melem_reg <= melem_next;
            mcnt_reg  <= mcnt_next;
            mlast_reg <= mlast_next;
        end
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = {1'b0, mcnt_reg, melem_reg, mstat_reg};
    assign m_tlast  = mlast_reg;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(DEPTH))
        else $error("occupancy above capacity");

    a_occ_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !in_acc |=> $stable(occ_reg))
        else $error("occupancy changed without an input transaction");

    a_list_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST) |-> (!s_tready && rem_reg != '0))
        else $error("listing state inconsistent");

    a_full_insert_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && full && (act == ACT_INS_FRONT || act == ACT_INS_BACK))
        |=> (occ_reg == CW'(DEPTH) && m_tdata[1:0] == STAT_FULL))
        else $error("insert into full list not refused");
`endif

endmodule

FILE: sv/ol_cell.sv
`timescale 1ns / 1ps

module ol_cell
    import ol_pkg::*;
(
    input  logic             clk,
    input  sel_t             sel,
    input  logic [VAL_W-1:0] new_val,
    input  logic [VAL_W-1:0] left_val,
    input  logic [VAL_W-1:0] right_val,
    input  logic [VAL_W-1:0] head_val,
    output logic [VAL_W-1:0] q
);

    logic [VAL_W-1:0] val_reg;
    logic [VAL_W-1:0] val_next;

    always_comb
    begin
        unique case (sel)
            SEL_HOLD:  val_next = val_reg;
            SEL_NEW:   val_next = new_val;
            SEL_LEFT:  val_next = left_val;
            SEL_RIGHT: val_next = right_val;
            SEL_HEAD:  val_next = head_val;
            default:   val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign q = val_reg;

endmodule

FILE: tb/sv/ordered_list_with_positional_insert_core_check.sv
`timescale 1ns / 1ps

module ordered_list_with_positional_insert_core_check
    import ol_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // action[2:0], value[34:3], position[39:35]
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,   // status[1:0], element[33:2], count[38:34], zero[39]
    input  logic             m_tlast,
    output int               fails,
    output int               pending,
    output int               results_seen,
    output int               full_seen,
    output int               badpos_seen,
    output int               empty_seen
);

    typedef struct packed {
        stat_t            status;
        logic [VAL_W-1:0] element;
        logic [CNT_W-1:0] count;
        logic             last;
    } list_result_t;

    list_result_t     awaited[$];
    logic [VAL_W-1:0] row_mirror [DEPTH_DEF];
    int               occupancy;

    task automatic post_status(input stat_t st);
        list_result_t r;
        r.status  = st;
        r.element = '0;
        r.count   = occupancy[CNT_W-1:0];
        r.last    = 1'b1;
        awaited.push_back(r);
        if (st == STAT_FULL)
            full_seen++;
        if (st == STAT_BADPOS)
            badpos_seen++;
        if (st == STAT_EMPTY)
            empty_seen++;
    endtask

    task automatic apply_action(input logic [IN_W-1:0] item);
        logic [ACT_W-1:0] act;
        logic [VAL_W-1:0] val;
        logic [POS_W-1:0] pos;
        int               slot;
        list_result_t     r;
        act = item[2:0];
        val = item[34:3];
        pos = item[39:35];
        case (act)
            ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS:
            begin
                if (act == ACT_INS_FRONT)
                    slot = 0;
                else if (act == ACT_INS_BACK)
                    slot = occupancy;
                else
                    slot = int'(pos) - 1;
                if (act == ACT_INS_POS && (pos == 0 || int'(pos) > occupancy + 1))
                    post_status(STAT_BADPOS);
                else if (occupancy >= DEPTH_DEF)
                    post_status(STAT_FULL);
                else
                begin
                    for (int k = occupancy; k > slot; k--)
                        row_mirror[k] = row_mirror[k-1];
                    row_mirror[slot] = val;
                    occupancy++;
                    post_status(STAT_OK);
                end
            end
            ACT_DEL_FRONT, ACT_DEL_BACK:
            begin
                if (occupancy == 0)
                    post_status(STAT_EMPTY);
                else
                begin
                    if (act == ACT_DEL_FRONT)
                        for (int k = 0; k < occupancy - 1; k++)
                            row_mirror[k] = row_mirror[k+1];
                    occupancy--;
                    post_status(STAT_OK);
                end
            end
            ACT_LIST:
            begin
                if (occupancy == 0)
                    post_status(STAT_EMPTY);
                else
                    for (int k = 0; k < occupancy; k++)
                    begin
                        r.status  = STAT_OK;
                        r.element = row_mirror[k];
                        r.count   = occupancy[CNT_W-1:0];
                        r.last    = (k == occupancy - 1);
                        awaited.push_back(r);
                    end
            end
            default:
                post_status(STAT_OK);
        endcase
    endtask

    always @(posedge clk)
    begin : watch
        list_result_t got;
        list_result_t want;
        if (!rst_n)
        begin
            fails        = 0;
            pending      = 0;
            results_seen = 0;
            full_seen    = 0;
            badpos_seen  = 0;
            empty_seen   = 0;
            occupancy    = 0;
            awaited.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status  = stat_t'(m_tdata[1:0]);
                got.element = m_tdata[33:2];
                got.count   = m_tdata[38:34];
                got.last    = m_tlast;
                results_seen++;
                if (awaited.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result: status %0d element %0d count %0d last %0b",
                                 got.status, $signed(got.element), got.count, got.last);
                end
                else
                begin
                    want = awaited.pop_front();
                    if (got !== want)
                    begin
                        fails++;
                        if (fails <= 10)
                        begin
                            $display("result differs: expected status %0d element %0d count %0d last %0b",
                                     want.status, $signed(want.element), want.count, want.last);
                            $display("                got status %0d element %0d count %0d last %0b",
                                     got.status, $signed(got.element), got.count, got.last);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                apply_action(s_tdata);
            pending = awaited.size();
        end
    end

endmodule

FILE: tb/sv/ordered_list_with_positional_insert_core_test.sv
`timescale 1ns / 1ps

module ordered_list_with_positional_insert_core_test;
    import ol_pkg::*;

    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 300;
    localparam int SEG_ITEMS   = 60;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;

    int fails;
    int pending;
    int results_seen;
    int full_seen;
    int badpos_seen;
    int empty_seen;

    int  cycles       = 0;
    int  actions_sent = 0;
    int  fill_level   = 0;
    bit  quiet        = 1'b0;
    bit  hold_req     = 1'b0;
    bit  hold_done    = 1'b0;

    always #2 clk = ~clk;

    ordered_list_with_positional_insert_core #(.DEPTH(DEPTH_DEF)) DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    ordered_list_with_positional_insert_core_check checker_inst
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .fails        (fails),
        .pending      (pending),
        .results_seen (results_seen),
        .full_seen    (full_seen),
        .badpos_seen  (badpos_seen),
        .empty_seen   (empty_seen)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("ordered_list_with_positional_insert_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        @(posedge clk);
        forever
        begin
            if (quiet)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
        end
    end

    task automatic send_action(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val,
                               input logic [POS_W-1:0] pos);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= {8'($urandom()), 32'($urandom())};
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pos, val, act};
        do
            @(posedge clk);
        while (!s_tready);
        actions_sent++;
        case (act)
            ACT_INS_FRONT, ACT_INS_BACK:
                if (fill_level < DEPTH_DEF)
                    fill_level++;
            ACT_INS_POS:
                if (pos >= 1 && int'(pos) <= fill_level + 1 && fill_level < DEPTH_DEF)
                    fill_level++;
            ACT_DEL_FRONT, ACT_DEL_BACK:
                if (fill_level > 0)
                    fill_level--;
            default:
                ;
        endcase
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    task automatic random_action(input int insert_pct);
        int               r;
        int               rp;
        logic [ACT_W-1:0] act;
        logic [VAL_W-1:0] val;
        logic [POS_W-1:0] pos;
        r  = $urandom_range(0, 99);
        rp = $urandom_range(0, 99);
        if (r < 3)
            act = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
        else if (r < 13)
            act = ACT_LIST;
        else if (r < 13 + insert_pct)
        begin
            case ($urandom_range(0, 3))
                0:       act = ACT_INS_FRONT;
                1:       act = ACT_INS_BACK;
                default: act = ACT_INS_POS;
            endcase
        end
        else
            act = $urandom_range(0, 1) ? ACT_DEL_BACK : ACT_DEL_FRONT;
        case ($urandom_range(0, 9))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7FFF_FFFF;
            2:       val = 32'hFFFF_FFFF;
            default: val = $urandom();
        endcase
        if (act != ACT_INS_POS || rp >= 85)
            pos = 5'($urandom_range(0, 31));
        else if (rp < 70)
            pos = 5'($urandom_range(1, fill_level + 1));
        else if (rp < 77)
            pos = '0;
        else
            pos = 5'($urandom_range(fill_level + 2, 31));
        send_action(act, val, pos);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_action(ACT_LIST, 32'h0, 5'd0);
        send_action(ACT_DEL_FRONT, 32'hFFFF_FFFF, 5'd31);
        send_action(ACT_DEL_BACK, 32'h0, 5'd0);
        send_action(ACT_INS_POS, 32'h1234_5678, 5'd0);
        send_action(ACT_INS_POS, 32'h1234_5678, 5'd2);
        send_action(ACT_INS_FRONT, 32'h8000_0000, 5'd0);
        send_action(ACT_INS_BACK, 32'h7FFF_FFFF, 5'd0);
        send_action(ACT_INS_POS, 32'h0, 5'd2);
        send_action(ACT_INS_POS, 32'hFFFF_FFFF, 5'd1);
        send_action(ACT_INS_POS, 32'h5555_5555, 5'd5);
        send_action(ACT_INS_POS, 32'hAAAA_AAAA, 5'd31);
        send_action(ACT_SPARE_LO, 32'hFFFF_FFFF, 5'd31);
        send_action(ACT_SPARE_HI, 32'h0, 5'd0);
        send_action(ACT_LIST, 32'h0, 5'd0);
        send_action(ACT_DEL_FRONT, 32'h0, 5'd0);
        send_action(ACT_DEL_BACK, 32'h0, 5'd0);
        send_action(ACT_LIST, 32'h0, 5'd0);
        while (fill_level < DEPTH_DEF)
            send_action(ACT_INS_BACK, $urandom(), 5'($urandom_range(0, 31)));
        send_action(ACT_INS_FRONT, 32'h0BAD_0BAD, 5'd0);
        send_action(ACT_INS_POS, 32'h0BAD_0BAD, 5'd17);
        send_action(ACT_INS_POS, 32'h0BAD_0BAD, 5'd18);
        send_action(ACT_LIST, 32'h0, 5'd0);
        wait_drained();

        for (int seg = 0; seg < 4; seg++)
        begin
            quiet = (seg == 3);
            for (int i = 0; i < SEG_ITEMS; i++)
            begin
                if (seg == 1 && i == 10)
                    hold_req = 1'b1;
                random_action(seg[0] ? 25 : 60);
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        $display("ran %0d actions and checked %0d results", actions_sent, results_seen);
        $display("status cases seen: full %0d, bad position %0d, empty %0d",
                 full_seen, badpos_seen, empty_seen);
        if (fails == 0 && pending == 0)
            $display("ordered_list_with_positional_insert_core: match");
        else
            $display("ordered_list_with_positional_insert_core: mismatch");
        $finish;
    end

endmodule

FILE: files.f
sv/ol_pkg.sv
sv/ol_cell.sv
sv/ordered_list_with_positional_insert_core.sv
tb/sv/ordered_list_with_positional_insert_core_check.sv
tb/sv/ordered_list_with_positional_insert_core_test.sv
